// File: rtl/bilinear_texture_sampler_core_defines.svh
// ---------------------------------------------------------------------------
// Bilinear texture sampler assertion macros
// Shorthand for clocked implication checks on aclk.
// ---------------------------------------------------------------------------
`ifndef BILINEAR_TEXTURE_SAMPLER_CORE_DEFINES_SVH
`define BILINEAR_TEXTURE_SAMPLER_CORE_DEFINES_SVH

// same-cycle implication
`define BTS_ASSERT_NOW(lbl, dis, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BTS_ASSERT_NEXT(lbl, dis, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bts_pkg.sv
// ---------------------------------------------------------------------------
// Bilinear texture sampler package
// Shared widths, constants, command codes and the front-to-back command type.
// ---------------------------------------------------------------------------
package bts_pkg;

    localparam int TEX_DEPTH   = 65536;
    localparam int TEX_AW      = $clog2(TEX_DEPTH);
    localparam int DIM_W       = 9;
    localparam int CRD_W       = 18;
    localparam int FRAC_W      = 16;
    localparam int POS_W       = FRAC_W + DIM_W;
    localparam int LIN_W       = 2 * DIM_W;
    localparam int INDEX_W     = 16;
    localparam int ARGB_W      = 32;
    localparam int TEXEL_W     = 24;
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;
    localparam int LEVEL_W     = 16;
    localparam int WGT_W       = 2 * FRAC_W + 1;
    localparam int ACC_W       = WGT_W + CHAN_W - 1;
    localparam int CELL_W      = FRAC_W + 7;
    localparam int CHECK_CELLS = 50;
    localparam int BLEND_TAPS  = 4;
    localparam int SLOT_W      = $clog2(BLEND_TAPS);
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [FRAC_W:0]    ONE_Q16    = 17'h10000;
    localparam logic [LEVEL_W-1:0] GRAY_HALF  = 16'h7F80;
    localparam logic [LEVEL_W-1:0] GRAY_3Q    = 16'hBF40;
    localparam logic [LEVEL_W-1:0] BLACK      = 16'h0000;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 16'hFF00;

    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT    = 2'd2;

    localparam logic OP_WRITE = 1'b0;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_CONST,
        CMD_NEAREST,
        CMD_BLEND
    } bts_kind_t;

    // addr0 is the top-left tap (or write address), addr2 the tap one row below
    typedef struct packed {
        bts_kind_t           kind;
        logic [LIN_W-1:0]    addr0;
        logic [LIN_W-1:0]    addr2;
        logic [FRAC_W-1:0]   fu;
        logic [FRAC_W-1:0]   fv;
        logic [TEXEL_W-1:0]  data;
    } bts_cmd_t;

endpackage

// File: rtl/bts_front.sv
// ---------------------------------------------------------------------------
// Bilinear texture sampler front end
// Accepts items, scales coordinates and classifies each item into a command.
// ---------------------------------------------------------------------------
module bts_front import bts_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_op,
    input  logic [INDEX_W-1:0]      s_texel_index,
    input  logic [ARGB_W-1:0]       s_texel_value,
    input  logic signed [CRD_W-1:0] s_u_coord,
    input  logic signed [CRD_W-1:0] s_v_coord,
    input  logic [DIM_W-1:0]        tex_width,
    input  logic [DIM_W-1:0]        tex_height,
    input  logic                    texture_present,
    output logic                    cmd_valid,
    input  logic                    cmd_ready,
    output bts_cmd_t                cmd
);

    typedef struct packed {
        logic                is_write;
        logic [INDEX_W-1:0]  index;
        logic [TEXEL_W-1:0]  data;
        logic                bad;
        logic                parity;
        logic [POS_W-1:0]    pu;
        logic [POS_W-1:0]    pv;
    } bts_pre_t;

    logic       a_valid_reg;
    bts_pre_t   a_reg;
    bts_pre_t   a_next;
    logic       b_valid_reg;
    bts_cmd_t   b_reg;
    bts_cmd_t   b_next;
    logic       a_move;
    logic       b_move;

    logic [FRAC_W-1:0] uc;
    logic [FRAC_W-1:0] vc;
    logic [CELL_W-1:0] u_cells;
    logic [CELL_W-1:0] v_cells;
    logic              u_bad;
    logic              v_bad;

    logic [DIM_W-1:0]  x;
    logic [DIM_W-1:0]  y;
    logic [DIM_W:0]    y1;
    logic              interior;

    assign b_move  = b_valid_reg && cmd_ready;
    assign a_move  = a_valid_reg && (!b_valid_reg || b_move);
    assign s_ready = !a_valid_reg || a_move;

    // stage A: range check, clamp, scale
    always_comb begin
        u_bad   = s_u_coord[CRD_W-1] || (s_u_coord[FRAC_W] && (s_u_coord[FRAC_W-1:0] != '0));
        v_bad   = s_v_coord[CRD_W-1] || (s_v_coord[FRAC_W] && (s_v_coord[FRAC_W-1:0] != '0));
        uc      = s_u_coord[FRAC_W] ? '1 : s_u_coord[FRAC_W-1:0];
        vc      = s_v_coord[FRAC_W] ? '1 : s_v_coord[FRAC_W-1:0];
        u_cells = CELL_W'(s_u_coord[FRAC_W:0]) * CELL_W'(CHECK_CELLS);
        v_cells = CELL_W'(s_v_coord[FRAC_W:0]) * CELL_W'(CHECK_CELLS);

        a_next.is_write = (s_op == OP_WRITE);
        a_next.index    = s_texel_index;
        a_next.data     = s_texel_value[TEXEL_W-1:0];
        a_next.bad      = u_bad || v_bad;
        a_next.parity   = u_cells[FRAC_W] ^ v_cells[FRAC_W];
        a_next.pu       = POS_W'(uc) * POS_W'(tex_width);
        a_next.pv       = POS_W'(vc) * POS_W'(tex_height);
    end

    // stage B: classify and form tap addresses
    always_comb begin
        x        = a_reg.pu[POS_W-1:FRAC_W];
        y        = a_reg.pv[POS_W-1:FRAC_W];
        y1       = {1'b0, y} + 1'b1;
        interior = (({1'b0, x} + 1'b1) < {1'b0, tex_width}) && (y1 < {1'b0, tex_height});

        b_next.kind  = CMD_NEAREST;
        b_next.addr0 = LIN_W'(x) + LIN_W'(tex_width) * LIN_W'(y);
        b_next.addr2 = LIN_W'(x) + LIN_W'(tex_width) * LIN_W'(y1);
        b_next.fu    = a_reg.pu[FRAC_W-1:0];
        b_next.fv    = a_reg.pv[FRAC_W-1:0];
        b_next.data  = TEXEL_W'(BLACK);

        if (a_reg.is_write) begin
            b_next.kind  = CMD_WRITE;
            b_next.addr0 = LIN_W'(a_reg.index);
            b_next.data  = a_reg.data;
        end else if (a_reg.bad) begin
            b_next.kind = CMD_CONST;
        end else if (!texture_present) begin
            b_next.kind = CMD_CONST;
            b_next.data = TEXEL_W'(a_reg.parity ? GRAY_HALF : GRAY_3Q);
        end else if ((tex_width == '0) || (tex_height == '0)) begin
            b_next.kind = CMD_CONST;
        end else if (interior) begin
            b_next.kind = CMD_BLEND;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end
            if (!b_valid_reg || b_move) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_reg <= a_next;
        end
        if (a_move) begin
            b_reg <= b_next;
        end
    end

    assign cmd_valid = b_valid_reg;
    assign cmd       = b_reg;

endmodule

// File: rtl/bts_queue.sv
// ---------------------------------------------------------------------------
// Bilinear texture sampler command queue
// Small FIFO that lets the front end and the back end stall independently.
// ---------------------------------------------------------------------------
module bts_queue import bts_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    output logic     push_ready,
    input  bts_cmd_t push_cmd,
    output logic     pop_valid,
    input  logic     pop_ready,
    output bts_cmd_t pop_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bts_cmd_t          slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/bts_back.sv
// ---------------------------------------------------------------------------
// Bilinear texture sampler back end
// Owns the texel memory, fetches taps one per cycle unless held, blends them.
// ---------------------------------------------------------------------------
module bts_back import bts_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  bts_cmd_t           cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [LEVEL_W-1:0] m_red_level,
    output logic [LEVEL_W-1:0] m_green_level,
    output logic [LEVEL_W-1:0] m_blue_level
);

    typedef struct packed {
        bts_kind_t           kind;
        logic                first;
        logic                last;
        logic                oob;
        logic [WGT_W-1:0]    wt;
        logic [LEVEL_W-1:0]  shade;
    } bts_slot_t;

    logic [TEXEL_W-1:0]  tex_mem [TEX_DEPTH];
    logic [TEXEL_W-1:0]  rd_data_reg;

    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic                slot_last;
    logic                back_en;
    logic                issue;
    logic [LIN_W-1:0]    slot_addr;
    logic [FRAC_W:0]     gu;
    logic [FRAC_W:0]     gv;
    logic [WGT_W-1:0]    wt_full;
    bts_slot_t           s2_next;
    bts_slot_t           s2_reg;
    logic                s2_valid_reg;

    logic [TEXEL_W-1:0]  texel;
    logic [CHAN_W-1:0]   chan  [NUM_CHAN];
    logic [ACC_W-1:0]    prod  [NUM_CHAN];
    logic [ACC_W-1:0]    sum   [NUM_CHAN];
    logic [ACC_W-1:0]    acc_reg [NUM_CHAN];
    logic [LEVEL_W-1:0]  level_next [NUM_CHAN];
    logic [LEVEL_W-1:0]  level_reg  [NUM_CHAN];
    logic                m_valid_reg;

    // hold the whole back pipeline while a result waits unclaimed
    assign back_en   = !m_valid_reg || m_ready;
    assign issue     = cmd_valid && back_en;
    assign slot_last = (cmd.kind != CMD_BLEND) || (slot_reg == SLOT_W'(BLEND_TAPS - 1));
    assign cmd_ready = issue && slot_last;
    assign slot_next = slot_last ? '0 : slot_reg + 1'b1;

    // tap order: top-left, top-right, bottom-left, bottom-right
    always_comb begin
        slot_addr = (slot_reg[1] ? cmd.addr2 : cmd.addr0) + LIN_W'(slot_reg[0]);
        gu        = slot_reg[0] ? {1'b0, cmd.fu} : ONE_Q16 - {1'b0, cmd.fu};
        gv        = slot_reg[1] ? {1'b0, cmd.fv} : ONE_Q16 - {1'b0, cmd.fv};
        wt_full   = WGT_W'(gu) * WGT_W'(gv);

        s2_next.kind  = cmd.kind;
        s2_next.first = (slot_reg == '0);
        s2_next.last  = slot_last;
        s2_next.oob   = (slot_addr >= LIN_W'(TEX_DEPTH));
        s2_next.wt    = wt_full;
        s2_next.shade = cmd.data[LEVEL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (issue && (cmd.kind == CMD_WRITE)) begin
            tex_mem[cmd.addr0[TEX_AW-1:0]] <= cmd.data;
        end
        if (issue && (cmd.kind inside {CMD_NEAREST, CMD_BLEND})) begin
            rd_data_reg <= tex_mem[slot_addr[TEX_AW-1:0]];
        end
    end

    // weigh the fetched tap and accumulate
    always_comb begin
        texel = s2_reg.oob ? '0 : rd_data_reg;
        for (int c = 0; c < NUM_CHAN; c++) begin
            chan[c] = texel[TEXEL_W-1-CHAN_W*c -: CHAN_W];
            prod[c] = ACC_W'(chan[c]) * ACC_W'(s2_reg.wt);
            sum[c]  = s2_reg.first ? prod[c] : acc_reg[c] + prod[c];
            case (s2_reg.kind)
                CMD_BLEND:   level_next[c] = sum[c][ACC_W-1 -: LEVEL_W];
                CMD_NEAREST: level_next[c] = {chan[c], CHAN_W'(0)};
                default:     level_next[c] = s2_reg.shade;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg     <= '0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (back_en) begin
            if (cmd_valid) begin
                slot_reg <= slot_next;
            end
            s2_valid_reg <= issue && (cmd.kind != CMD_WRITE);
            m_valid_reg  <= s2_valid_reg && s2_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (back_en) begin
            s2_reg <= s2_next;
            for (int c = 0; c < NUM_CHAN; c++) begin
                if (s2_valid_reg && (s2_reg.kind == CMD_BLEND)) begin
                    acc_reg[c] <= sum[c];
                end
                if (s2_valid_reg && s2_reg.last) begin
                    level_reg[c] <= level_next[c];
                end
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_red_level   = level_reg[0];
    assign m_green_level = level_reg[1];
    assign m_blue_level  = level_reg[2];

endmodule

// File: rtl/bilinear_texture_sampler_core.sv
// Throughput: one item per cycle for writes and non-blended samples while the result
// channel does not stall; a bilinear sample holds the single texel memory port until
// its last tap is fetched (one tap fetch per cycle).
// Reset: synchronous active-low aresetn clears control state and the queue; registers
// return to width 1, height 1, texture absent. Texel memory is not cleared.
// ---------------------------------------------------------------------------
// Bilinear texture sampler core
// Texel store with bilinear filtering; front end and back end joined by a queue.
// ---------------------------------------------------------------------------
module bilinear_texture_sampler_core import bts_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [DIM_W-1:0]        cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_op,
    input  logic [INDEX_W-1:0]      s_texel_index,
    input  logic [ARGB_W-1:0]       s_texel_value,
    input  logic signed [CRD_W-1:0] s_u_coord,
    input  logic signed [CRD_W-1:0] s_v_coord,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [LEVEL_W-1:0]      m_red_level,
    output logic [LEVEL_W-1:0]      m_green_level,
    output logic [LEVEL_W-1:0]      m_blue_level
);

    logic [DIM_W-1:0] tex_width_reg;
    logic [DIM_W-1:0] tex_height_reg;
    logic             texture_present_reg;

    logic     fq_valid;
    logic     fq_ready;
    bts_cmd_t fq_cmd;
    logic     qb_valid;
    logic     qb_ready;
    bts_cmd_t qb_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_width_reg       <= DIM_W'(1);
            tex_height_reg      <= DIM_W'(1);
            texture_present_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TEX_WIDTH:  tex_width_reg       <= cfg_data;
                CFG_TEX_HEIGHT: tex_height_reg      <= cfg_data;
                CFG_PRESENT:    texture_present_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    bts_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_texel_index   (s_texel_index),
        .s_texel_value   (s_texel_value),
        .s_u_coord       (s_u_coord),
        .s_v_coord       (s_v_coord),
        .tex_width       (tex_width_reg),
        .tex_height      (tex_height_reg),
        .texture_present (texture_present_reg),
        .cmd_valid       (fq_valid),
        .cmd_ready       (fq_ready),
        .cmd             (fq_cmd)
    );

    bts_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_cmd   (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_cmd    (qb_cmd)
    );

    bts_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (qb_valid),
        .cmd_ready     (qb_ready),
        .cmd           (qb_cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_level   (m_red_level),
        .m_green_level (m_green_level),
        .m_blue_level  (m_blue_level)
    );

endmodule

// File: rtl/bts_checker.sv
// ---------------------------------------------------------------------------
// Bilinear texture sampler port checker
// Watches the top-level ports for result stability, level range and reset.
// ---------------------------------------------------------------------------
`include "bilinear_texture_sampler_core_defines.svh"

module bts_checker import bts_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [LEVEL_W-1:0] m_red_level,
    input logic [LEVEL_W-1:0] m_green_level,
    input logic [LEVEL_W-1:0] m_blue_level
);

    `BTS_ASSERT_NEXT(a_result_held, !aresetn, m_valid && !m_ready, m_valid && $stable(m_red_level) && $stable(m_green_level) && $stable(m_blue_level), "stalled result transaction changed")

    `BTS_ASSERT_NOW(a_level_range, !aresetn, m_valid, (m_red_level <= FULL_LEVEL) && (m_green_level <= FULL_LEVEL) && (m_blue_level <= FULL_LEVEL), "level above full scale")

    `BTS_ASSERT_NEXT(a_reset_no_result, 1'b0, !aresetn, !m_valid, "result valid right after reset")

    `BTS_ASSERT_NEXT(a_reset_ready, 1'b0, !aresetn, s_ready, "input not ready right after reset")

endmodule

bind bilinear_texture_sampler_core bts_checker u_bts_checker (.*);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bilinear texture sampler core testbench
// Streams texel writes and samples through the valid/ready channels, keeps a
// mirror of the texel store and the registers, predicts every sampled color
// and compares each result channel against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;
    import bts_pkg::*;

    localparam int CLK_PERIOD       = 2;
    localparam int RESET_CYCLES     = 11;
    localparam int IDLE_PCT         = 8;
    localparam int SETTLE_CYCLES    = 40;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT      = 5000;
    localparam int MAX_REPORTS      = 40;
    localparam logic OP_SAMPLE      = ~OP_WRITE;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } rgb_levels_t;

    typedef int tap_list_t [BLEND_TAPS];

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index     = CFG_TEX_WIDTH;
    logic [DIM_W-1:0]         cfg_data      = '0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic                     s_op          = OP_WRITE;
    logic [INDEX_W-1:0]       s_texel_index = '0;
    logic [ARGB_W-1:0]        s_texel_value = '0;
    logic signed [CRD_W-1:0]  s_u_coord     = '0;
    logic signed [CRD_W-1:0]  s_v_coord     = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic [LEVEL_W-1:0]       m_red_level;
    logic [LEVEL_W-1:0]       m_green_level;
    logic [LEVEL_W-1:0]       m_blue_level;

    // mirror of the block's texel store and registers
    logic [TEXEL_W-1:0] texel_mirror [TEX_DEPTH];
    bit                 texel_loaded [TEX_DEPTH];
    int                 cur_width   = 1;
    int                 cur_height  = 1;
    bit                 cur_present = 1'b0;

    rgb_levels_t pending_levels [$];
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          stall_cycles   = 0;
    bit          quiet_mode     = 1'b0;
    int          hold_requests  = 0;
    int          hold_seen      = 0;
    int          hold_left      = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    bilinear_texture_sampler_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_texel_index (s_texel_index),
        .s_texel_value (s_texel_value),
        .s_u_coord     (s_u_coord),
        .s_v_coord     (s_v_coord),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_level   (m_red_level),
        .m_green_level (m_green_level),
        .m_blue_level  (m_blue_level)
    );

    function automatic logic [TEXEL_W-1:0] read_texel(input int addr);
        if (addr >= TEX_DEPTH) return '0;
        return texel_mirror[addr];
    endfunction

    // Caller guarantees an in-range coordinate, a present texture and nonzero sizes.
    function automatic int locate_taps(input int su, input int sv, output tap_list_t taps,
                                       output int fu, output int fv);
        int uc, vc, pu, pv, x, y;
        uc = (su > 65535) ? 65535 : su;
        vc = (sv > 65535) ? 65535 : sv;
        pu = uc * cur_width;
        pv = vc * cur_height;
        x  = pu >> FRAC_W;
        y  = pv >> FRAC_W;
        fu = pu & 'hFFFF;
        fv = pv & 'hFFFF;
        taps[0] = x + cur_width * y;
        taps[1] = x + 1 + cur_width * y;
        taps[2] = x + cur_width * (y + 1);
        taps[3] = x + 1 + cur_width * (y + 1);
        if (x + 1 < cur_width && y + 1 < cur_height) return BLEND_TAPS;
        return 1;
    endfunction

    function automatic rgb_levels_t predict_levels(input logic signed [CRD_W-1:0] u,
                                                   input logic signed [CRD_W-1:0] v);
        rgb_levels_t        lv;
        tap_list_t          taps;
        logic [TEXEL_W-1:0] t [BLEND_TAPS];
        logic [LEVEL_W-1:0] lvl [NUM_CHAN];
        longint             wt [BLEND_TAPS];
        longint             acc;
        int                 su, sv, fu, fv, n, sh, ch, k;
        su = int'(u);
        sv = int'(v);
        lv = '{BLACK, BLACK, BLACK};
        if (su < 0 || su > int'(ONE_Q16) || sv < 0 || sv > int'(ONE_Q16)) return lv;
        if (!cur_present) begin
            if (((((su * CHECK_CELLS) >> FRAC_W) ^ ((sv * CHECK_CELLS) >> FRAC_W)) & 1) != 0)
                lv = '{GRAY_HALF, GRAY_HALF, GRAY_HALF};
            else
                lv = '{GRAY_3Q, GRAY_3Q, GRAY_3Q};
            return lv;
        end
        if (cur_width == 0 || cur_height == 0) return lv;
        n = locate_taps(su, sv, taps, fu, fv);
        for (k = 0; k < n; k++) t[k] = read_texel(taps[k]);
        wt[0] = longint'(int'(ONE_Q16) - fu) * longint'(int'(ONE_Q16) - fv);
        wt[1] = longint'(fu) * longint'(int'(ONE_Q16) - fv);
        wt[2] = longint'(int'(ONE_Q16) - fu) * longint'(fv);
        wt[3] = longint'(fu) * longint'(fv);
        for (ch = 0; ch < NUM_CHAN; ch++) begin
            sh = (NUM_CHAN - 1 - ch) * CHAN_W;
            if (n == 1) begin
                lvl[ch] = {t[0][sh +: CHAN_W], 8'h00};
            end else begin
                acc = 0;
                for (k = 0; k < BLEND_TAPS; k++) acc += longint'(t[k][sh +: CHAN_W]) * wt[k];
                lvl[ch] = LEVEL_W'(acc >> 24);
            end
        end
        lv.red   = lvl[0];
        lv.green = lvl[1];
        lv.blue  = lvl[2];
        return lv;
    endfunction

    task automatic report_mismatch(input string what, input logic [LEVEL_W-1:0] got,
                                   input logic [LEVEL_W-1:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] ERROR %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Offer one transaction and hold it until accepted; call at a rising edge.
    task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
                             input logic [ARGB_W-1:0] value,
                             input logic signed [CRD_W-1:0] u,
                             input logic signed [CRD_W-1:0] v);
        if (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < IDLE_PCT);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_texel_index <= idx;
        s_texel_value <= value;
        s_u_coord     <= u;
        s_v_coord     <= v;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (op == OP_WRITE) begin
            texel_mirror[idx] = value[TEXEL_W-1:0];
            texel_loaded[idx] = 1'b1;
        end else begin
            pending_levels.push_back(predict_levels(u, v));
        end
    endtask

    // Load any tap the sample would read that has never been written, then sample.
    task automatic send_sample(input logic signed [CRD_W-1:0] u,
                               input logic signed [CRD_W-1:0] v);
        tap_list_t taps;
        int        su, sv, fu, fv, n, k;
        su = int'(u);
        sv = int'(v);
        if (cur_present && cur_width != 0 && cur_height != 0 && su >= 0 && sv >= 0 &&
            su <= int'(ONE_Q16) && sv <= int'(ONE_Q16)) begin
            n = locate_taps(su, sv, taps, fu, fv);
            for (k = 0; k < n; k++)
                if (taps[k] < TEX_DEPTH && !texel_loaded[taps[k]])
                    send_item(OP_WRITE, INDEX_W'(taps[k]), $urandom,
                              CRD_W'($urandom), CRD_W'($urandom));
        end
        send_item(OP_SAMPLE, INDEX_W'($urandom), $urandom, u, v);
    endtask

    // Drop valid, wait for every pending result, then let trailing writes retire.
    task automatic quiesce();
        s_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_settings(input int w, input int h, input bit present);
        quiesce();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_TEX_WIDTH;
        cfg_data  <= DIM_W'(w);
        @(posedge aclk);
        cfg_index <= CFG_TEX_HEIGHT;
        cfg_data  <= DIM_W'(h);
        @(posedge aclk);
        cfg_index <= CFG_PRESENT;
        cfg_data  <= DIM_W'(present);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_width   = w;
        cur_height  = h;
        cur_present = present;
    endtask

    function automatic logic signed [CRD_W-1:0] pick_coord();
        case ($urandom_range(9))
            0:       return CRD_W'(ONE_Q16);
            1:       return '0;
            2, 3:    return CRD_W'($urandom);
            default: return CRD_W'($urandom_range(65536));
        endcase
    endfunction

    task automatic random_traffic(input int budget);
        int first, span;
        first = items_sent;
        span  = cur_width * cur_height;
        if (span == 0 || span > TEX_DEPTH) span = TEX_DEPTH;
        while (items_sent - first < budget) begin
            if ($urandom_range(99) < 15)
                send_item(OP_WRITE,
                          $urandom_range(1) ? INDEX_W'($urandom_range(span - 1))
                                            : INDEX_W'($urandom),
                          $urandom, pick_coord(), pick_coord());
            else
                send_sample(pick_coord(), pick_coord());
        end
    endtask

    // Reset settings: checkerboard fallback and out-of-range coordinates.
    task automatic test_fallback_and_range();
        send_item(OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF, '0, '0);
        send_item(OP_WRITE, 16'h0000, 32'h0000_0000, '1, '1);
        send_sample(18'sd0, 18'sd0);
        send_sample(18'sd65536, 18'sd65536);
        send_sample(18'sd1311, 18'sd0);
        send_sample(18'sd0, 18'sd1311);
        send_sample(-18'sd1, 18'sd0);
        send_sample(18'sd65537, 18'sd0);
        send_sample(18'sd0, -18'sd131072);
        send_sample(18'sd0, 18'sd131071);
    endtask

    task automatic test_small_texture_blend();
        apply_settings(2, 2, 1'b1);
        send_item(OP_WRITE, 16'd0, 32'hFFFF_FFFF, '0, '0);
        send_item(OP_WRITE, 16'd1, 32'h0000_0000, '0, '0);
        send_item(OP_WRITE, 16'd2, 32'hAA55_AA55, '0, '0);
        send_item(OP_WRITE, 16'd3, 32'h1280_FF01, '0, '0);
        send_sample(18'sd0, 18'sd0);
        send_sample(18'sd16384, 18'sd16384);
        send_sample(18'sd32767, 18'sd1);
        send_sample(18'sd65536, 18'sd65536);
        send_sample(18'sd65536, 18'sd0);
        send_sample(18'sd0, 18'sd65536);
    endtask

    // Zero sizes give black; oversized textures fetch beyond the store and read zero.
    task automatic test_degenerate_sizes();
        apply_settings(0, 2, 1'b1);
        send_sample(18'sd100, 18'sd100);
        apply_settings(3, 0, 1'b1);
        send_sample(18'sd65536, 18'sd0);
        apply_settings(511, 511, 1'b1);
        send_sample(18'sd65536, 18'sd65536);
        send_sample(18'sd30000, 18'sd40000);
    endtask

    task automatic test_random_settings();
        apply_settings(256, 256, 1'b0);
        random_traffic(150);
        apply_settings(1, 1, 1'b1);
        random_traffic(120);
        apply_settings(5, 3, 1'b1);
        random_traffic(200);
        apply_settings(2, 40, 1'b1);
        random_traffic(150);
        apply_settings(37, 1, 1'b1);
        random_traffic(150);
        apply_settings(256, 256, 1'b1);
        random_traffic(200);
        apply_settings(300, 220, 1'b1);
        random_traffic(120);
        apply_settings(0, 7, 1'b1);
        random_traffic(30);
        apply_settings(9, 0, 1'b1);
        random_traffic(30);
        apply_settings(8, 8, 1'b1);
        random_traffic(400);
    endtask

    task automatic test_quiet_stretch();
        apply_settings(16, 16, 1'b1);
        quiet_mode <= 1'b1;
        random_traffic(250);
        quiet_mode <= 1'b0;
    endtask

    // Stall the result side long enough for the block to back up into its input.
    task automatic test_sink_backpressure();
        int n;
        apply_settings(8, 8, 1'b1);
        hold_requests <= hold_requests + 1;
        for (n = 0; n < 60; n++)
            send_sample(CRD_W'($urandom_range(57000)), CRD_W'($urandom_range(57000)));
        quiesce();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_fallback_and_range();
        test_small_texture_blend();
        test_degenerate_sizes();
        test_random_settings();
        test_quiet_stretch();
        test_sink_backpressure();
        quiesce();
        if (mismatch_count == 0)
            $display("bilinear_texture_sampler_core: match");
        else
            $display("bilinear_texture_sampler_core: mismatch");
        $finish;
    end

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= SINK_HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        rgb_levels_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_levels.size() == 0) begin
                report_mismatch("result with no sample pending", m_red_level, BLACK);
            end else begin
                want = pending_levels.pop_front();
                if (m_red_level !== want.red)
                    report_mismatch("red_level", m_red_level, want.red);
                if (m_green_level !== want.green)
                    report_mismatch("green_level", m_green_level, want.green);
                if (m_blue_level !== want.blue)
                    report_mismatch("blue_level", m_blue_level, want.blue);
            end
        end
    end

    // Count cycles with no transaction on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("[%0t] ERROR no transaction for %0d cycles", $realtime, STALL_LIMIT);
            $display("bilinear_texture_sampler_core: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
